FILE: rtl/core/rba_pkg.sv
// Package for the rectangle blitter: word types, mode codes, register
// indexes and controller states. Depends on nothing.
package rba_pkg;

    // Host command codes carried in the mode field.
    localparam logic [1:0] MODE_WR_SRC = 2'd0;
    localparam logic [1:0] MODE_WR_DST = 2'd1;
    localparam logic [1:0] MODE_RD_DST = 2'd2;
    localparam logic [1:0] MODE_BLIT   = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_COL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ROW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_COL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_ROW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LEVEL  = 3'd7;

    localparam int CFG_DATA_W = 8;
    localparam logic [7:0] ALPHA_FULL = 8'd255;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] byte_addr;
        logic [7:0]  write_data;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic host_wr_src;
        logic host_wr_dst;
        logic host_rd;
        logic load_base;
        logic step;
        logic out_load;
        logic out_status;
        logic out_from_read;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rect_fits;
        logic rect_empty;
        logic last_byte;
        logic pipe_busy;
    } dp_stat_t;

endpackage

FILE: rtl/core/rba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/core/rba_ctrl.sv
// Controller state machine of the blitter: input and result handshakes and
// the sequencing of host accesses and blits. Depends on rba_pkg.
module rba_ctrl import rba_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] in_mode,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);
    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        // The result register is free, or its word leaves at this edge.
        s_ready    = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
        accept     = s_valid && s_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_mode)
                        MODE_WR_SRC: begin
                            cmd.host_wr_src = 1'b1;
                            cmd.out_load    = 1'b1;
                        end
                        MODE_WR_DST: begin
                            cmd.host_wr_dst = 1'b1;
                            cmd.out_load    = 1'b1;
                        end
                        MODE_RD_DST: begin
                            cmd.host_rd = 1'b1;
                            state_next  = ST_READ;
                        end
                        default: begin
                            if (!stat.rect_fits) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = 1'b1;
                            end else if (stat.rect_empty) begin
                                cmd.out_load = 1'b1;
                            end else begin
                                cmd.load_base = 1'b1;
                                state_next    = ST_RUN;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                cmd.out_load      = 1'b1;
                cmd.out_from_read = 1'b1;
                state_next        = ST_IDLE;
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (stat.last_byte) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    assign m_valid = m_valid_reg;

    // A new result must never overwrite a word that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten before it was taken");

    // The final byte of a blit hands over to draining the pipeline.
    a_last_to_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && stat.last_byte) |=> (state_reg == ST_DRAIN))
        else $error("blit did not drain after its final byte");
endmodule

FILE: rtl/core/rba_datapath.sv
// Datapath of the blitter: configuration registers, both image stores,
// address counters, the blend pipeline and the result register.
// Depends on rba_pkg and rba_ram.
module rba_datapath import rba_pkg::*; #(
    parameter int IMG_WIDTH  = 64,
    parameter int IMG_HEIGHT = 64,
    parameter int CHANNELS   = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              s_data,
    output out_word_t             m_data,
    input  ctrl_cmd_t             cmd,
    output dp_stat_t              stat
);
    localparam int STORE_BYTES = IMG_WIDTH * IMG_HEIGHT * CHANNELS;
    localparam int ROW_BYTES   = IMG_WIDTH * CHANNELS;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int SW          = $clog2(ROW_BYTES + 1);

    // Configuration registers.
    logic [5:0] src_col_reg, src_row_reg, dst_col_reg, dst_row_reg;
    logic [6:0] rect_width_reg, rect_height_reg;
    logic       blend_enable_reg;
    logic [7:0] alpha_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_col_reg      <= '0;
            src_row_reg      <= '0;
            rect_width_reg   <= '0;
            rect_height_reg  <= '0;
            dst_col_reg      <= '0;
            dst_row_reg      <= '0;
            blend_enable_reg <= 1'b0;
            alpha_level_reg  <= ALPHA_FULL;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SRC_COL:      src_col_reg      <= cfg_data[5:0];
                REG_SRC_ROW:      src_row_reg      <= cfg_data[5:0];
                REG_RECT_WIDTH:   rect_width_reg   <= cfg_data[6:0];
                REG_RECT_HEIGHT:  rect_height_reg  <= cfg_data[6:0];
                REG_DST_COL:      dst_col_reg      <= cfg_data[5:0];
                REG_DST_ROW:      dst_row_reg      <= cfg_data[5:0];
                REG_BLEND_ENABLE: blend_enable_reg <= cfg_data[0];
                REG_ALPHA_LEVEL:  alpha_level_reg  <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Bounds check of the rectangle against both images.
    assign stat.rect_fits =
        ((32'(src_col_reg) + 32'(rect_width_reg))  <= 32'(IMG_WIDTH))  &&
        ((32'(dst_col_reg) + 32'(rect_width_reg))  <= 32'(IMG_WIDTH))  &&
        ((32'(src_row_reg) + 32'(rect_height_reg)) <= 32'(IMG_HEIGHT)) &&
        ((32'(dst_row_reg) + 32'(rect_height_reg)) <= 32'(IMG_HEIGHT));
    assign stat.rect_empty = (rect_width_reg == 7'd0) || (rect_height_reg == 7'd0);

    // Host access decoding.
    logic          host_in_range;
    logic [AW-1:0] host_addr;
    assign host_in_range = 32'(s_data.byte_addr) < 32'(STORE_BYTES);
    assign host_addr     = AW'(s_data.byte_addr);

    // Blit address generation.
    logic [AW-1:0] src_addr_reg, dst_addr_reg, src_base_reg, dst_base_reg;
    logic [SW-1:0] col_cnt_reg, span_reg;
    logic [6:0]    row_cnt_reg;
    logic [31:0]   src_start, dst_start;
    logic          row_end;

    assign src_start = 32'(src_row_reg) * 32'(ROW_BYTES) + 32'(src_col_reg) * 32'(CHANNELS);
    assign dst_start = 32'(dst_row_reg) * 32'(ROW_BYTES) + 32'(dst_col_reg) * 32'(CHANNELS);
    assign row_end   = (col_cnt_reg == SW'(span_reg - SW'(1)));
    assign stat.last_byte = row_end && (row_cnt_reg == 7'(rect_height_reg - 7'd1));

    always_ff @(posedge aclk) begin
        if (cmd.load_base) begin
            src_base_reg <= AW'(src_start);
            dst_base_reg <= AW'(dst_start);
            src_addr_reg <= AW'(src_start);
            dst_addr_reg <= AW'(dst_start);
            span_reg     <= SW'(32'(rect_width_reg) * 32'(CHANNELS));
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
        end else if (cmd.step) begin
            if (row_end) begin
                // Move both pointers to the start of the next row.
                col_cnt_reg  <= '0;
                row_cnt_reg  <= 7'(row_cnt_reg + 7'd1);
                src_base_reg <= AW'(src_base_reg + AW'(ROW_BYTES));
                dst_base_reg <= AW'(dst_base_reg + AW'(ROW_BYTES));
                src_addr_reg <= AW'(src_base_reg + AW'(ROW_BYTES));
                dst_addr_reg <= AW'(dst_base_reg + AW'(ROW_BYTES));
            end else begin
                col_cnt_reg  <= SW'(col_cnt_reg + SW'(1));
                src_addr_reg <= AW'(src_addr_reg + AW'(1));
                dst_addr_reg <= AW'(dst_addr_reg + AW'(1));
            end
        end
    end

    // Blend pipeline: read, multiply, write back.
    logic          v1_reg, v2_reg;
    logic [AW-1:0] d1_addr_reg, d2_addr_reg;
    logic [15:0]   prod_s_reg, prod_d_reg;
    logic [7:0]    s2_reg;
    logic [7:0]    src_rdata, dst_rdata, blend_byte;
    logic [15:0]   blend_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.step;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        d1_addr_reg <= dst_addr_reg;
        d2_addr_reg <= d1_addr_reg;
        s2_reg      <= src_rdata;
        prod_s_reg  <= 16'(src_rdata) * 16'(alpha_level_reg);
        prod_d_reg  <= 16'(dst_rdata) * 16'(8'(ALPHA_FULL - alpha_level_reg));
    end

    // The two weights add up to 255, so the sum never leaves 16 bits.
    assign blend_sum  = prod_s_reg + prod_d_reg;
    assign blend_byte = blend_enable_reg ? blend_sum[15:8] : s2_reg;
    assign stat.pipe_busy = v1_reg || v2_reg;

    // Image stores.
    logic          dst_we;
    logic [AW-1:0] dst_waddr, dst_raddr;
    logic [7:0]    dst_wdata;

    assign dst_we    = v2_reg || (cmd.host_wr_dst && host_in_range);
    assign dst_waddr = v2_reg ? d2_addr_reg : host_addr;
    assign dst_wdata = v2_reg ? blend_byte : s_data.write_data;
    assign dst_raddr = cmd.step ? dst_addr_reg : host_addr;

    rba_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_src_ram (
        .aclk  (aclk),
        .we    (cmd.host_wr_src && host_in_range),
        .waddr (host_addr),
        .wdata (s_data.write_data),
        .raddr (src_addr_reg),
        .rdata (src_rdata)
    );

    rba_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_dst_ram (
        .aclk  (aclk),
        .we    (dst_we),
        .waddr (dst_waddr),
        .wdata (dst_wdata),
        .raddr (dst_raddr),
        .rdata (dst_rdata)
    );

    // Result register; a read outside the image returns zero.
    logic      rd_ok_reg;
    out_word_t out_reg;

    always_ff @(posedge aclk) begin
        rd_ok_reg <= cmd.host_rd && host_in_range;
        if (cmd.out_load) begin
            out_reg.read_data <= (cmd.out_from_read && rd_ok_reg) ? dst_rdata : 8'd0;
            out_reg.status    <= cmd.out_status;
        end
    end

    assign m_data = out_reg;

    // The host never writes the destination while blit bytes are in flight.
    a_no_wr_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v2_reg && cmd.host_wr_dst))
        else $error("host write collides with blit write-back");

    // A result is only produced once the pipeline has emptied.
    a_result_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.pipe_busy)
        else $error("result produced while blit bytes are in flight");
endmodule

FILE: rtl/core/rect_blit_alpha_blend.sv
// Top level of the rectangle blitter with constant-alpha blending.
// Depends on rba_pkg, rba_ctrl, rba_datapath and rba_ram.
//
//  Channel  Ports                                   Word
//  input    s_valid, s_ready, s_data                in_word_t (mode, byte_addr, write_data)
//  result   m_valid, m_ready, m_data                out_word_t (read_data, status)
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  register index and byte
//
// Byte writes and rejected or empty blits load their result word when accepted; a byte read
// loads its result from the registered read of the destination store.
// A blit moves one byte per cycle through the read, multiply and write-back stages,
// then drains those stages before its result word is loaded.
// Reset clears the controller and the configuration registers; the stores are not cleared.
// A stalled result word holds the next input off until it is taken.
module rect_blit_alpha_blend import rba_pkg::*; #(
    parameter int IMG_WIDTH  = 64,
    parameter int IMG_HEIGHT = 64,
    parameter int CHANNELS   = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    rba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .in_mode (s_data.mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rba_datapath #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .CHANNELS   (CHANNELS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );
endmodule
